// ----- rtl/apery_pkg.sv -----
package apery_pkg;

  localparam int RADIX_BITS    = 4;
  localparam int PC_W          = 5;
  localparam int MODULUS_RESET = 17;
  localparam int COEF_CUBE     = 34;
  localparam int COEF_SQUARE   = 51;
  localparam int COEF_LINEAR   = 27;
  localparam int COEF_CONST    = 5;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [2:0] {K_OP, K_RD, K_WR, K_JMP, K_EMIT} kind_t;
  typedef enum logic [1:0] {C_NEVER, C_ALWAYS, C_IDX0, C_IDX1} cond_t;
  typedef enum logic [4:0] {
    S_ZERO, S_ONE, S_K5, S_K27, S_K34, S_K51, S_P, S_N, S_Q, S_TAB,
    S_INV, S_T, S_N3, S_COEF, S_NUM, S_PREV, S_OLDER
  } src_t;
  typedef enum logic {D_P, D_IDX} dsel_t;
  typedef enum logic [2:0] {R_QR, R_INV, R_T, R_N3, R_COEF, R_NUM, R_VAL} dst_t;
  typedef enum logic {W_ENTRY, W_ONE} wsel_t;

  typedef struct packed {
    kind_t kind;
    cond_t cond;
    pc_t   target;
    src_t  a;
    src_t  b;
    src_t  c;
    dsel_t dsel;
    dst_t  dst;
    logic  neg;
    wsel_t wsel;
  } ucw_t;

  typedef struct packed {
    logic  load;
    logic  start;
    logic  wr;
    logic  mem_rd;
    logic  mem_wr;
    logic  emit;
    src_t  a;
    src_t  b;
    src_t  c;
    dsel_t dsel;
    dst_t  dst;
    logic  neg;
    wsel_t wsel;
  } ctrl_t;

  typedef struct packed {
    logic idx_zero;
    logic idx_one;
    logic div_busy;
    logic div_done;
  } stat_t;

  localparam pc_t L_OUT  = 5'd16;
  localparam pc_t L_ZERO = 5'd17;
  localparam pc_t L_ONE  = 5'd19;

  localparam ucw_t UC_NOP = '{kind: K_JMP, cond: C_NEVER, target: '0, a: S_ZERO,
                              b: S_ZERO, c: S_ZERO, dsel: D_P, dst: R_T,
                              neg: 1'b0, wsel: W_ENTRY};

  function automatic ucw_t uc_jmp(cond_t cd, pc_t tg);
    ucw_t w;
    w        = UC_NOP;
    w.cond   = cd;
    w.target = tg;
    return w;
  endfunction

  function automatic ucw_t uc_kind(kind_t k, wsel_t ws);
    ucw_t w;
    w      = UC_NOP;
    w.kind = k;
    w.wsel = ws;
    return w;
  endfunction

  // dividend a*b+c, divided by p or by the index
  function automatic ucw_t uc_op(src_t a, src_t b, src_t c, dsel_t ds, dst_t r,
                                 logic ng);
    ucw_t w;
    w      = UC_NOP;
    w.kind = K_OP;
    w.a    = a;
    w.b    = b;
    w.c    = c;
    w.dsel = ds;
    w.dst  = r;
    w.neg  = ng;
    return w;
  endfunction

  function automatic ucw_t ucode(pc_t pc);
    ucw_t w;
    unique case (pc)
      5'd0:  w = uc_jmp(C_IDX0, L_ZERO);
      5'd1:  w = uc_jmp(C_IDX1, L_ONE);
      5'd2:  w = uc_op(S_P, S_ONE, S_ZERO, D_IDX, R_QR, 1'b0);
      5'd3:  w = uc_kind(K_RD, W_ENTRY);
      5'd4:  w = uc_op(S_Q, S_TAB, S_ZERO, D_P, R_INV, 1'b1);
      5'd5:  w = uc_kind(K_WR, W_ENTRY);
      5'd6:  w = uc_op(S_N, S_N, S_ZERO, D_P, R_T, 1'b0);
      5'd7:  w = uc_op(S_T, S_N, S_ZERO, D_P, R_N3, 1'b0);
      5'd8:  w = uc_op(S_N, S_K34, S_K51, D_P, R_T, 1'b0);
      5'd9:  w = uc_op(S_T, S_N, S_K27, D_P, R_T, 1'b0);
      5'd10: w = uc_op(S_T, S_N, S_K5, D_P, R_COEF, 1'b0);
      5'd11: w = uc_op(S_N3, S_OLDER, S_ZERO, D_P, R_T, 1'b1);
      5'd12: w = uc_op(S_COEF, S_PREV, S_T, D_P, R_NUM, 1'b0);
      5'd13: w = uc_op(S_INV, S_INV, S_ZERO, D_P, R_T, 1'b0);
      5'd14: w = uc_op(S_T, S_INV, S_ZERO, D_P, R_T, 1'b0);
      5'd15: w = uc_op(S_NUM, S_T, S_ZERO, D_P, R_VAL, 1'b0);
      L_OUT: w = uc_kind(K_EMIT, W_ENTRY);
      L_ZERO: w = uc_kind(K_WR, W_ONE);
      5'd18: begin
        w        = uc_op(S_ONE, S_ONE, S_ZERO, D_P, R_VAL, 1'b0);
        w.cond   = C_ALWAYS;
        w.target = L_OUT;
      end
      L_ONE: begin
        w        = uc_op(S_K5, S_ONE, S_ZERO, D_P, R_VAL, 1'b0);
        w.cond   = C_ALWAYS;
        w.target = L_OUT;
      end
      default: w = uc_jmp(C_ALWAYS, L_OUT);
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/apery_ifs.sv -----
interface apery_cmd_if ();
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface apery_term_if #(parameter int W = 12) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] term_index;
  logic [W-1:0] term_value;
  logic         last_term;

  modport source (output valid, output term_index, output term_value, output last_term,
                  input ready);
  modport sink (input valid, input term_index, input term_value, input last_term,
                output ready);
endinterface

// ----- rtl/apery_sequence_mod_prime.sv -----
// Each term after terms 0 and 1 is computed by twelve serial steps of the shared
// radix-16 divide/modulo unit.
// One term in flight; the next cmd transaction is taken the cycle after a term is produced.
// rst (synchronous) clears the index and stored terms and sets the modulus to 17;
// the inverse table is not cleared.
module apery_sequence_mod_prime import apery_pkg::*; #(
  parameter int MODULUS_WIDTH = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [MODULUS_WIDTH-1:0] cfg_wdata,
  apery_cmd_if.sink                cmd,
  apery_term_if.source             term
);

  localparam int W = MODULUS_WIDTH;

  logic [W-1:0] modulus;
  logic [W-1:0] p;
  logic         go;
  logic         busy;
  logic         out_free;
  ctrl_t        ctrl;
  stat_t        stat;
  logic [W-1:0] dp_index;
  logic [W-1:0] dp_value;
  logic         dp_last;
  logic         ovalid;
  logic [W-1:0] oidx;
  logic [W-1:0] oval;
  logic         olast;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= W'(MODULUS_RESET);
    end else if (cfg_we) begin
      modulus <= cfg_wdata;
    end
  end

  assign p = (modulus < W'(2)) ? W'(2) : modulus;

  assign cmd.ready = !busy;
  assign go        = cmd.valid && !busy;
  assign out_free  = !ovalid || term.ready;

  apery_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .out_free (out_free),
    .stat     (stat),
    .ctrl     (ctrl),
    .busy     (busy)
  );

  apery_dp #(.W(W)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .restart    (cmd.restart),
    .p          (p),
    .ctrl       (ctrl),
    .stat       (stat),
    .term_index (dp_index),
    .term_value (dp_value),
    .term_last  (dp_last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (ctrl.emit) begin
      ovalid <= 1'b1;
    end else if (term.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      oidx  <= dp_index;
      oval  <= dp_value;
      olast <= dp_last;
    end
  end

  assign term.valid      = ovalid;
  assign term.term_index = oidx;
  assign term.term_value = oval;
  assign term.last_term  = olast;

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> !cmd.ready)
    else $error("second transaction taken while a term is in progress");

endmodule

// ----- rtl/apery_divu.sv -----
module apery_divu import apery_pkg::*; #(
  parameter int W  = 12,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [W-1:0]  divisor,
  output logic          busy,
  output logic          done,
  output logic [W-1:0]  quot,
  output logic [W-1:0]  rem
);

  localparam int CYC = DW / RADIX_BITS;
  localparam int CW  = (CYC > 1) ? $clog2(CYC) : 1;

  logic [CW-1:0] cnt;
  logic [DW-1:0] sh;
  logic [W-1:0]  dvs;
  logic [DW-1:0] s_w;
  logic [W-1:0]  r_w;
  logic [W-1:0]  q_w;
  logic [W:0]    r_t;

  // RADIX_BITS restoring steps a cycle
  always_comb begin
    r_w = rem;
    s_w = sh;
    q_w = quot;
    r_t = '0;
    for (int k = 0; k < RADIX_BITS; k++) begin
      r_t = {r_w, s_w[DW-1]};
      s_w = {s_w[DW-2:0], 1'b0};
      if (r_t >= {1'b0, dvs}) begin
        r_w = W'(r_t - {1'b0, dvs});
        q_w = {q_w[W-2:0], 1'b1};
      end else begin
        r_w = r_t[W-1:0];
        q_w = {q_w[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(CYC - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh   <= dividend;
      rem  <= '0;
      quot <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      sh   <= s_w;
      rem  <= r_w;
      quot <= q_w;
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> rem < dvs)
    else $error("remainder not below divisor");

endmodule

// ----- rtl/apery_dp.sv -----
module apery_dp import apery_pkg::*; #(
  parameter int W = 12
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         restart,
  input  logic [W-1:0] p,
  input  ctrl_t        ctrl,
  output stat_t        stat,
  output logic [W-1:0] term_index,
  output logic [W-1:0] term_value,
  output logic         term_last
);

  localparam int OW    = (W > 6) ? W : 6;
  localparam int PW    = 2 * OW;
  localparam int DW    = ((PW + RADIX_BITS - 1) / RADIX_BITS) * RADIX_BITS;
  localparam int DEPTH = 2 ** W;

  logic [W-1:0] cur_idx;
  logic [W-1:0] idx;
  logic [W-1:0] prev;
  logic [W-1:0] older;
  logic [W-1:0] q;
  logic [W-1:0] r;
  logic [W-1:0] tabd;
  logic [W-1:0] inv;
  logic [W-1:0] t;
  logic [W-1:0] n3;
  logic [W-1:0] coef;
  logic [W-1:0] num;
  logic [W-1:0] val;
  logic [W-1:0] tab [DEPTH];

  logic [W-1:0]  n;
  logic [OW-1:0] opa;
  logic [OW-1:0] opb;
  logic [OW-1:0] opc;
  logic [PW-1:0] prod;
  logic [PW-1:0] sum;
  logic [DW-1:0] dividend;
  logic [W-1:0]  divisor;
  logic          div_busy;
  logic          div_done;
  logic [W-1:0]  quot;
  logic [W-1:0]  rem;
  logic [W-1:0]  res;
  logic [W-1:0]  wa;
  logic [W-1:0]  wd;

  assign n = idx - 1'b1;

  function automatic logic [OW-1:0] pick(src_t s);
    logic [OW-1:0] v;
    unique case (s)
      S_ZERO:  v = '0;
      S_ONE:   v = OW'(1);
      S_K5:    v = OW'(COEF_CONST);
      S_K27:   v = OW'(COEF_LINEAR);
      S_K34:   v = OW'(COEF_CUBE);
      S_K51:   v = OW'(COEF_SQUARE);
      S_P:     v = OW'(p);
      S_N:     v = OW'(n);
      S_Q:     v = OW'(q);
      S_TAB:   v = OW'(tabd);
      S_INV:   v = OW'(inv);
      S_T:     v = OW'(t);
      S_N3:    v = OW'(n3);
      S_COEF:  v = OW'(coef);
      S_NUM:   v = OW'(num);
      S_PREV:  v = OW'(prev);
      S_OLDER: v = OW'(older);
      default: v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    opa = pick(ctrl.a);
    opb = pick(ctrl.b);
    opc = pick(ctrl.c);
  end

  assign prod     = opa * opb;
  assign sum      = prod + PW'(opc);
  assign dividend = DW'(sum);
  assign divisor  = (ctrl.dsel == D_IDX) ? idx : p;

  apery_divu #(.W(W), .DW(DW)) u_divu (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.start),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  // negate mod p
  assign res = (ctrl.neg && rem != '0) ? p - rem : (ctrl.neg ? '0 : rem);

  assign wa = (ctrl.wsel == W_ONE) ? W'(1) : idx;
  assign wd = (ctrl.wsel == W_ONE) ? W'(1) : inv;

  always_ff @(posedge clk) begin
    if (ctrl.mem_wr) begin
      tab[wa] <= wd;
    end
    if (ctrl.mem_rd) begin
      tabd <= tab[r];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      idx <= (restart || cur_idx >= p - 1'b1) ? '0 : cur_idx;
    end
    if (ctrl.wr) begin
      unique case (ctrl.dst)
        R_QR: begin
          q <= quot;
          r <= rem;
        end
        R_INV:  inv  <= res;
        R_T:    t    <= res;
        R_N3:   n3   <= res;
        R_COEF: coef <= res;
        R_NUM:  num  <= res;
        R_VAL:  val  <= res;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_idx <= '0;
      prev    <= '0;
      older   <= '0;
    end else if (ctrl.emit) begin
      prev    <= val;
      older   <= (idx == '0) ? '0 : prev;
      cur_idx <= (idx >= p - W'(2)) ? '0 : idx + 1'b1;
    end
  end

  assign stat.idx_zero = (idx == '0);
  assign stat.idx_one  = (idx == W'(1));
  assign stat.div_busy = div_busy;
  assign stat.div_done = div_done;

  assign term_index = idx;
  assign term_value = val;
  assign term_last  = (idx == p - W'(2));

endmodule

// ----- rtl/apery_seq.sv -----
module apery_seq import apery_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  go,
  input  logic  out_free,
  input  stat_t stat,
  output ctrl_t ctrl,
  output logic  busy
);

  logic running;
  logic issued;
  pc_t  pc;
  ucw_t word;
  logic jump;
  logic step;

  assign word = ucode(pc);

  always_comb begin
    unique case (word.cond)
      C_NEVER:  jump = 1'b0;
      C_ALWAYS: jump = 1'b1;
      C_IDX0:   jump = stat.idx_zero;
      C_IDX1:   jump = stat.idx_one;
    endcase
  end

  always_comb begin
    step = 1'b0;
    if (running) begin
      unique case (word.kind) inside
        K_OP:               step = issued && stat.div_done;
        K_EMIT:             step = out_free;
        K_RD, K_WR, K_JMP:  step = 1'b1;
        default:            step = 1'b0;
      endcase
    end
  end

  assign ctrl.load   = go;
  assign ctrl.start  = running && (word.kind == K_OP) && !issued;
  assign ctrl.wr     = running && (word.kind == K_OP) && issued && stat.div_done;
  assign ctrl.mem_rd = running && (word.kind == K_RD);
  assign ctrl.mem_wr = running && (word.kind == K_WR);
  assign ctrl.emit   = running && (word.kind == K_EMIT) && out_free;
  assign ctrl.a      = word.a;
  assign ctrl.b      = word.b;
  assign ctrl.c      = word.c;
  assign ctrl.dsel   = word.dsel;
  assign ctrl.dst    = word.dst;
  assign ctrl.neg    = word.neg;
  assign ctrl.wsel   = word.wsel;

  assign busy = running;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      issued  <= 1'b0;
      pc      <= '0;
    end else begin
      if (go) begin
        running <= 1'b1;
        pc      <= '0;
      end else if (step) begin
        if (word.kind == K_EMIT) begin
          running <= 1'b0;
        end
        pc <= jump ? word.target : pc_t'(pc + 1'b1);
      end
      if (ctrl.start) begin
        issued <= 1'b1;
      end else if (ctrl.wr) begin
        issued <= 1'b0;
      end
    end
  end

  a_issued_on_op: assert property (@(posedge clk) disable iff (rst)
    issued |-> word.kind == K_OP)
    else $error("operation flag set outside an arithmetic step");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |-> !stat.div_busy)
    else $error("divider started while busy");

endmodule
